### rtl/abbreviation_substituter_core_defines.svh
// assertion macros for the abbreviation substituter rtl
// no dependencies; included by the modules that carry assertions
`ifndef ABBREVIATION_SUBSTITUTER_CORE_DEFINES_SVH
`define ABBREVIATION_SUBSTITUTER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ABS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define ABS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/abs_pkg.sv
// types, pattern tables and case folding for the abbreviation substituter
// no dependencies
package abs_pkg;

	localparam int PEND_DEPTH  = 3;
	localparam int MAX_RES     = 4;
	localparam int FORM_CNT    = 8;
	localparam int PAT_LEN_MAX = 4;
	localparam int REP_LEN_MAX = 3;
	localparam int STEP_CNT    = 4;
	localparam int WIN_SPAN    = 8;

	typedef logic [7:0] byte_t;
	typedef logic [1:0] pcnt_t;
	typedef logic [2:0] rcnt_t;
	typedef logic [2:0] wpos_t;
	typedef logic [2:0] form_idx_t;
	typedef logic [2:0] plen_t;
	typedef logic [1:0] rlen_t;

	typedef struct packed {
		byte_t [PEND_DEPTH-1:0] bytes;
		pcnt_t                  cnt;
	} pend_t;

	typedef struct packed {
		byte_t [MAX_RES-1:0] bytes;
		rcnt_t               cnt;
		logic                eot;
	} res_t;

	localparam byte_t PAT [FORM_CNT][PAT_LEN_MAX] = '{
		'{"u", ".", "n", "."},
		'{"u", ".", "k", "."},
		'{"u", ".", "s", "."},
		'{"a", ".", "m", "."},
		'{"p", ".", "m", "."},
		'{"i", ".", "e", "."},
		'{"e", ".", "g", "."},
		'{".", ".", ".", 8'h00}
	};

	localparam plen_t PAT_LEN [FORM_CNT] = '{
		3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3
	};

	localparam byte_t REP [FORM_CNT][REP_LEN_MAX] = '{
		'{"U", "N", 8'h00},
		'{"U", "K", 8'h00},
		'{"U", "S", 8'h00},
		'{"a", "m", 8'h00},
		'{"p", "m", 8'h00},
		'{"i", "e", 8'h00},
		'{"e", "g", 8'h00},
		'{8'hE2, 8'h80, 8'hA6}
	};

	localparam rlen_t REP_LEN [FORM_CNT] = '{
		2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3
	};

	// ascii upper case to lower case, everything else unchanged
	function automatic byte_t fold(input byte_t c);
		if (c >= "A" && c <= "Z") begin
			return byte_t'(c + 8'd32);
		end
		return c;
	endfunction

endpackage

### rtl/abs_in_if.sv
// input channel: text bytes with end-of-text mark
// depends on abs_pkg
interface abs_in_if import abs_pkg::*;;
	logic  valid;
	logic  ready;
	byte_t in_byte;
	logic  end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

### rtl/abs_out_if.sv
// output channel: rewritten text bytes with run and text end marks
// depends on abs_pkg
interface abs_out_if import abs_pkg::*;;
	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  run_last;
	logic  text_done;

	modport source (output valid, output out_byte, output run_last, output text_done,
		input ready);
	modport sink   (input valid, input out_byte, input run_last, input text_done,
		output ready);
endinterface

### rtl/abs_match.sv
// window matcher: held bytes plus the new byte, rewritten in one pass
// depends on abs_pkg
module abs_match import abs_pkg::*; (
	input  pend_t pend,
	input  byte_t in_byte,
	input  logic  end_of_text,
	output pend_t pend_next,
	output res_t  res
);

	byte_t win [WIN_SPAN];

	always_comb begin
		rcnt_t     len;
		rcnt_t     pos;
		rcnt_t     rem;
		rcnt_t     n;
		logic      stop;
		logic      hit;
		logic      grow;
		logic      mism;
		form_idx_t hk;

		for (int i = 0; i < WIN_SPAN; i++) begin
			win[i] = '0;
		end
		for (int i = 0; i < PEND_DEPTH; i++) begin
			win[i] = pend.bytes[i];
		end
		win[{1'b0, pend.cnt}] = in_byte;

		len       = rcnt_t'({1'b0, pend.cnt} + 3'd1);
		pos       = '0;
		n         = '0;
		stop      = 1'b0;
		rem       = '0;
		hit       = 1'b0;
		grow      = 1'b0;
		mism      = 1'b0;
		hk        = '0;
		res.bytes = '0;

		for (int s = 0; s < STEP_CNT; s++) begin
			if (!stop && pos < len) begin
				rem  = rcnt_t'(len - pos);
				hit  = 1'b0;
				grow = 1'b0;
				hk   = '0;
				for (int k = 0; k < FORM_CNT; k++) begin
					mism = 1'b0;
					for (int i = 0; i < PAT_LEN_MAX; i++) begin
						if (i < PAT_LEN[k] && i < rem &&
							fold(win[wpos_t'(pos + i)]) != PAT[k][i]) begin
							mism = 1'b1;
						end
					end
					if (!hit && !mism && rem >= PAT_LEN[k]) begin
						hit = 1'b1;
						hk  = form_idx_t'(k);
					end
					if (!mism && rem < PAT_LEN[k]) begin
						grow = 1'b1;
					end
				end
				if (hit) begin
					for (int j = 0; j < REP_LEN_MAX; j++) begin
						if (j < REP_LEN[hk]) begin
							res.bytes[n[1:0]] = REP[hk][j];
							n = rcnt_t'(n + 3'd1);
						end
					end
					pos = rcnt_t'(pos + PAT_LEN[hk]);
				end else if (grow && !end_of_text) begin
					stop = 1'b1;
				end else begin
					res.bytes[n[1:0]] = win[pos];
					n   = rcnt_t'(n + 3'd1);
					pos = rcnt_t'(pos + 3'd1);
				end
			end
		end

		res.cnt = n;
		res.eot = end_of_text;

		pend_next.cnt = pcnt_t'(len - pos);
		for (int i = 0; i < PEND_DEPTH; i++) begin
			pend_next.bytes[i] = win[wpos_t'(pos + i)];
		end
	end

endmodule

### rtl/abs_outq.sv
// result register: holds up to four result bytes and, while the result channel is ready, hands them out one a cycle
// depends on abs_pkg, abs_out_if and the assertion macro header
`include "abbreviation_substituter_core_defines.svh"

module abs_outq import abs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  res_t     res,
	output logic     can_load,
	abs_out_if.source result
);

	byte_t bytes_q [MAX_RES];
	rcnt_t total_q;
	rcnt_t idx_q;
	logic  eot_q;
	logic  last;
	logic  take;

	assign last     = (rcnt_t'(idx_q + 3'd1) == total_q);
	assign take     = result.valid && result.ready;
	assign can_load = (idx_q == total_q) || (last && result.ready);

	assign result.valid     = (idx_q != total_q);
	assign result.out_byte  = bytes_q[idx_q[1:0]];
	assign result.run_last  = last;
	assign result.text_done = last && eot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			idx_q   <= '0;
		end else if (load) begin
			total_q <= res.cnt;
			idx_q   <= '0;
		end else if (take) begin
			idx_q <= rcnt_t'(idx_q + 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MAX_RES; i++) begin
				bytes_q[i] <= res.bytes[i];
			end
			eot_q <= res.eot;
		end
	end

	`ABS_ASSERT_SAME(a_idx_bound, clk, arst_n, 1'b1, idx_q <= total_q, "drain index beyond count")
	`ABS_ASSERT_SAME(a_load_free, clk, arst_n, load, (idx_q == total_q) || (last && take), "load over undelivered results")
	`ABS_ASSERT_NEXT(a_load_show, clk, arst_n, load && (res.cnt != '0), result.valid && (idx_q == '0), "loaded results not shown")

endmodule

### rtl/abbreviation_substituter_core.sv
// channel  dir  payload                              handshake
// text     in   in_byte[7:0], end_of_text            valid/ready
// result   out  out_byte[7:0], run_last, text_done   valid/ready
//
// one text byte is taken per cycle when it yields at most one result byte and
// the result channel is ready; a byte that yields several results holds the input
// until the result register drain reaches its last result byte
// reset clears the held-byte count and the result register's count and index, nothing else
// a stalled result holds its byte; input ready drops once a new transaction
// would overwrite results that are not yet taken
// depends on abs_pkg, abs_in_if, abs_out_if, abs_match, abs_outq
`include "abbreviation_substituter_core_defines.svh"

module abbreviation_substituter_core import abs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	abs_in_if.sink     text,
	abs_out_if.source  result
);

	byte_t [PEND_DEPTH-1:0] pend_bytes_q;
	pcnt_t                  pend_cnt_q;
	pend_t pend_q;
	pend_t pend_next;
	res_t  res;
	logic  can_load;
	logic  accept;

	assign pend_q.bytes = pend_bytes_q;
	assign pend_q.cnt   = pend_cnt_q;

	assign text.ready = can_load;
	assign accept     = text.valid && text.ready;

	abs_match u_match (
		.pend        (pend_q),
		.in_byte     (text.in_byte),
		.end_of_text (text.end_of_text),
		.pend_next   (pend_next),
		.res         (res)
	);

	abs_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.res      (res),
		.can_load (can_load),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= '0;
		end else if (accept) begin
			pend_cnt_q <= pend_next.cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_bytes_q <= pend_next.bytes;
		end
	end

	`ABS_ASSERT_NEXT(a_eot_flush, clk, arst_n, accept && text.end_of_text, pend_q.cnt == '0, "held bytes left after end of text")
	`ABS_ASSERT_SAME(a_no_result_holds, clk, arst_n, accept && !text.end_of_text && (res.cnt == '0), pend_next.cnt != '0, "byte dropped without result")

endmodule

### sim/tb_top.sv
// testbench for abbreviation_substituter_core: directed table then random text,
// every result checked against its directed row or an in-bench rewrite predictor
// depends on abs_pkg, abs_in_if, abs_out_if and the core rtl
`timescale 1ns / 100ps

module tb_top import abs_pkg::*;;

	localparam int ABBR_FORMS   = 8;
	localparam int PREDICTED    = -1;
	localparam int DIR_ROWS     = 25;
	localparam int RAND_ITEMS   = 205;
	localparam int HOLD_AT      = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_REPORTS  = 10;

	localparam byte_t ABBR_PAT [ABBR_FORMS][4] = '{
		'{"u", ".", "n", "."},
		'{"u", ".", "k", "."},
		'{"u", ".", "s", "."},
		'{"a", ".", "m", "."},
		'{"p", ".", "m", "."},
		'{"i", ".", "e", "."},
		'{"e", ".", "g", "."},
		'{".", ".", ".", 8'h00}
	};
	localparam int ABBR_PAT_LEN [ABBR_FORMS] = '{4, 4, 4, 4, 4, 4, 4, 3};
	localparam byte_t ABBR_SUB [ABBR_FORMS][3] = '{
		'{"U", "N", 8'h00},
		'{"U", "K", 8'h00},
		'{"U", "S", 8'h00},
		'{"a", "m", 8'h00},
		'{"p", "m", 8'h00},
		'{"i", "e", 8'h00},
		'{"e", "g", 8'h00},
		'{8'hE2, 8'h80, 8'hA6}
	};
	localparam int ABBR_SUB_LEN [ABBR_FORMS] = '{2, 2, 2, 2, 2, 2, 2, 3};
	localparam byte_t ABBR_LETTERS [10] = '{"u", "n", "k", "s", "a", "m", "p", "i", "e", "g"};

	typedef struct {
		byte_t       b;
		logic        eot;
		int          n;
		logic [31:0] bytes;
	} text_row_t;

	typedef struct packed {
		byte_t b;
		logic  run_last;
		logic  text_done;
	} rewritten_t;

	// typed results: first byte in the top bits
	text_row_t dir_rows [DIR_ROWS] = '{
		'{"x",   1'b0, 1, {"x", 24'h0}},
		'{8'h00, 1'b0, 1, {8'h00, 24'h0}},
		'{8'hFF, 1'b1, 1, {8'hFF, 24'h0}},
		'{"U",   1'b0, 0, 32'h0},
		'{".",   1'b0, 0, 32'h0},
		'{"N",   1'b0, 0, 32'h0},
		'{".",   1'b0, 2, {"UN", 16'h0}},
		'{"P",   1'b0, PREDICTED, 32'h0},
		'{".",   1'b0, PREDICTED, 32'h0},
		'{"m",   1'b0, PREDICTED, 32'h0},
		'{".",   1'b0, PREDICTED, 32'h0},
		'{".",   1'b0, 0, 32'h0},
		'{".",   1'b0, 0, 32'h0},
		'{".",   1'b0, 3, {8'hE2, 8'h80, 8'hA6, 8'h00}},
		'{"e",   1'b0, 0, 32'h0},
		'{".",   1'b0, 0, 32'h0},
		'{"g",   1'b1, 3, {"e.g", 8'h0}},
		'{"u",   1'b0, 0, 32'h0},
		'{".",   1'b0, 0, 32'h0},
		'{"s",   1'b0, 0, 32'h0},
		'{"x",   1'b0, 4, "u.sx"},
		'{"i",   1'b0, 0, 32'h0},
		'{".",   1'b0, 0, 32'h0},
		'{"e",   1'b0, 0, 32'h0},
		'{".",   1'b1, 2, {"ie", 16'h0}}
	};

	logic clk;
	logic arst_n;

	abs_in_if  text_if ();
	abs_out_if result_if ();

	abbreviation_substituter_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.result (result_if)
	);

	byte_t      held_bytes [3];
	int         held_cnt;
	rewritten_t rewritten_q [$];
	rewritten_t oldest;
	int         mismatch_cnt;
	int         checked_cnt;
	int         sent_cnt;
	int         texts_cnt;
	int         cycle_cnt;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic byte_t lower_ascii(input byte_t c);
		if (c >= "A" && c <= "Z") begin
			return byte_t'(c + 8'd32);
		end
		return c;
	endfunction

	function automatic byte_t noise_byte();
		byte_t c;
		case ($urandom_range(0, 9))
			0, 1, 2: c = ".";
			3, 4, 5: begin
				c = ABBR_LETTERS[$urandom_range(0, 9)];
				if ($urandom_range(0, 1)) begin
					c = byte_t'(c - 8'd32);
				end
			end
			6: c = " ";
			default: c = byte_t'($urandom_range(0, 255));
		endcase
		return c;
	endfunction

	function automatic int pick_gap(ref bit calm);
		if ($urandom_range(0, 24) == 0) begin
			calm = !calm;
		end
		return calm ? 0 : $urandom_range(0, 11);
	endfunction

	// leftmost, non-overlapping rewrite of held bytes plus one new byte
	task automatic rewrite_text_byte(input byte_t b, input logic eot, output byte_t res [4],
		output int n);
		byte_t win [4];
		int    len;
		int    pos;
		int    rem;
		int    hit;
		int    a;
		bit    grow;
		n = 0;
		len = held_cnt;
		for (int i = 0; i < len; i++) begin
			win[i] = held_bytes[i];
		end
		win[len] = b;
		len++;
		pos = 0;
		while (pos < len) begin
			rem = len - pos;
			hit = -1;
			grow = 1'b0;
			for (int k = 0; k < ABBR_FORMS && hit < 0; k++) begin
				a = 0;
				while (a < rem && a < ABBR_PAT_LEN[k] &&
					lower_ascii(win[pos + a]) == ABBR_PAT[k][a]) begin
					a++;
				end
				if (a == ABBR_PAT_LEN[k]) begin
					hit = k;
				end else if (a == rem) begin
					grow = 1'b1;
				end
			end
			if (hit >= 0) begin
				for (int i = 0; i < ABBR_SUB_LEN[hit]; i++) begin
					if (n < 4) begin
						res[n] = ABBR_SUB[hit][i];
						n++;
					end
				end
				pos += ABBR_PAT_LEN[hit];
			end else if (grow && !eot) begin
				break;
			end else begin
				if (n < 4) begin
					res[n] = win[pos];
					n++;
				end
				pos++;
			end
		end
		held_cnt = len - pos;
		for (int i = 0; i < held_cnt; i++) begin
			held_bytes[i] = win[pos + i];
		end
	endtask

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				rewritten_q.size());
			$display("FAIL abbreviation_substituter_core");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			checked_cnt <= checked_cnt + 1;
			if (rewritten_q.size() == 0) begin
				if (mismatch_cnt < MAX_REPORTS) begin
					$display("unexpected transaction: byte %h run_last %b text_done %b",
						result_if.out_byte, result_if.run_last, result_if.text_done);
				end
				mismatch_cnt <= mismatch_cnt + 1;
			end else begin
				oldest = rewritten_q.pop_front();
				if (result_if.out_byte !== oldest.b || result_if.run_last !== oldest.run_last ||
					result_if.text_done !== oldest.text_done) begin
					if (mismatch_cnt < MAX_REPORTS) begin
						$display("mismatch: expected byte %h run_last %b text_done %b, got %h %b %b",
							oldest.b, oldest.run_last, oldest.text_done, result_if.out_byte,
							result_if.run_last, result_if.text_done);
					end
					mismatch_cnt <= mismatch_cnt + 1;
				end
			end
		end
	end

	initial begin : result_sink
		int taken;
		int gap;
		bit calm;
		taken = 0;
		calm = 1'b0;
		result_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// one long hold so the core backs up into its input
			gap = (taken == HOLD_AT) ? HOLD_CYCLES : pick_gap(calm);
			if (gap > 0) begin
				result_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (result_if.valid !== 1'b1);
			taken++;
		end
	end

	initial begin : text_source
		text_row_t text_q [$];
		text_row_t row;
		byte_t     chunk [$];
		byte_t     c;
		byte_t     res [4];
		int        n;
		int        sel;
		int        k;
		int        cut;
		int        bad_pos;
		int        gap;
		bit        calm;
		arst_n <= 1'b0;
		text_if.valid <= 1'b0;
		text_if.in_byte <= 8'h00;
		text_if.end_of_text <= 1'b0;
		held_cnt = 0;
		mismatch_cnt = 0;
		checked_cnt = 0;
		sent_cnt = 0;
		texts_cnt = 0;
		cycle_cnt = 0;
		calm = 1'b0;

		foreach (dir_rows[i]) begin
			text_q.push_back(dir_rows[i]);
		end
		row.n = PREDICTED;
		row.bytes = 32'h0;
		while (text_q.size() < DIR_ROWS + RAND_ITEMS) begin
			chunk.delete();
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				// dotted form, random case; some cut short or with a bad byte
				k = $urandom_range(0, ABBR_FORMS - 1);
				cut = (sel < 15) ? $urandom_range(1, ABBR_PAT_LEN[k]) : ABBR_PAT_LEN[k];
				bad_pos = (sel < 15 && $urandom_range(0, 1)) ? $urandom_range(0, cut - 1) : -1;
				for (int a = 0; a < cut; a++) begin
					c = ABBR_PAT[k][a];
					if (a == bad_pos) begin
						c = noise_byte();
					end else if (c >= "a" && c <= "z" && $urandom_range(0, 1)) begin
						c = byte_t'(c - 8'd32);
					end
					chunk.push_back(c);
				end
			end else begin
				repeat ($urandom_range(1, 3)) chunk.push_back(noise_byte());
			end
			foreach (chunk[i]) begin
				row.b = chunk[i];
				row.eot = ($urandom_range(0, 19) == 0);
				text_q.push_back(row);
			end
		end
		text_q[text_q.size() - 1].eot = 1'b1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (text_q[j]) begin
			row = text_q[j];
			gap = pick_gap(calm);
			if (gap > 0) begin
				text_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			text_if.valid <= 1'b1;
			text_if.in_byte <= row.b;
			text_if.end_of_text <= row.eot;
			do @(posedge clk); while (text_if.ready !== 1'b1);
			rewrite_text_byte(row.b, row.eot, res, n);
			if (row.n != PREDICTED) begin
				n = row.n;
				for (int i = 0; i < n; i++) begin
					res[i] = row.bytes[31 - 8 * i -: 8];
				end
			end
			for (int i = 0; i < n; i++) begin
				rewritten_q.push_back({res[i], 1'(i == n - 1), 1'(row.eot && i == n - 1)});
			end
			sent_cnt++;
			if (row.eot) begin
				texts_cnt++;
			end
		end
		text_if.valid <= 1'b0;

		while (rewritten_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d text bytes over %0d texts (directed rows, then random forms and noise)",
			sent_cnt, texts_cnt);
		$display("%0d rewritten bytes compared, %0d mismatches", checked_cnt, mismatch_cnt);
		if (mismatch_cnt == 0) begin
			$display("PASS abbreviation_substituter_core");
		end else begin
			$display("FAIL abbreviation_substituter_core");
		end
		$finish;
	end

endmodule
